/* design/tes_pkg.sv */
// ----------------------------------------------------------------------------
// Truncated exponential sampler package
// Shared widths, register indexes and the -ln(1-u) Q2.16 lookup table.
// ----------------------------------------------------------------------------
package tes_pkg;

  // field widths
  localparam int unsigned RandW  = 32;
  localparam int unsigned DurW   = 31;
  localparam int unsigned MeanW  = 24;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 32;

  // table layout: top 5 bits pick the cell, next 16 bits interpolate
  localparam int unsigned CellW  = 5;
  localparam int unsigned FracW  = 16;
  localparam int unsigned CellLsb = 27;
  localparam int unsigned FracLsb = 11;
  localparam int unsigned QShift = 16;
  localparam int unsigned TabW   = 18;   // largest entry is 184320
  localparam int unsigned DiffW  = 15;   // largest cell step is 24833
  localparam int unsigned TabN   = 33;
  localparam int unsigned TabIdxW = 6;

  // scaled deviate after the mean multiply and the Q16 shift
  localparam int unsigned ScaledW = TabW + MeanW - QShift;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DIST_MODE = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_MS    = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_MS    = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEAN_MS   = 4'd3;

  // distribution modes
  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_EXP   = 1'b1;

  // -ln(1-u) at u = k/32, Q2.16
  localparam logic [TabW-1:0] NegLogTab [TabN] = '{
    18'd0,      18'd2064,   18'd4184,   18'd6364,   18'd8608,   18'd10921,
    18'd13307,  18'd15772,  18'd18322,  18'd20964,  18'd23706,  18'd26556,
    18'd29525,  18'd32624,  18'd35867,  18'd39270,  18'd42851,  18'd46632,
    18'd50639,  18'd54903,  18'd59461,  18'd64358,  18'd69649,  18'd75403,
    18'd81706,  18'd88670,  18'd96444,  18'd105226, 18'd115295, 18'd127085,
    18'd141335, 18'd159487, 18'd184320
  };

endpackage

/* design/tes_interp.sv */
// ----------------------------------------------------------------------------
// Table interpolation stages
// Looks up the cell end points, then interpolates the Q2.16 deviate.
// Two register stages; one request per cycle.
// ----------------------------------------------------------------------------
module tes_interp import tes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RandW-1:0]  rand_word_i,
  output logic              valid_o,
  output logic [TabW-1:0]   dev_o
);

  logic [CellW-1:0]   cell_sel;
  logic [TabIdxW-1:0] lo_idx;
  logic [TabIdxW-1:0] hi_idx;
  logic [TabW-1:0]    hi_val;

  logic               v1_q;
  logic [TabW-1:0]    lo_q;
  logic [DiffW-1:0]   diff_q;
  logic [FracW-1:0]   frac_q;

  logic [DiffW+FracW-1:0] step;
  logic [TabW-1:0]        dev_d;
  logic                   v2_q;
  logic [TabW-1:0]        dev_q;

  // pick cell end points
  assign cell_sel = rand_word_i[CellLsb +: CellW];
  assign lo_idx   = {1'b0, cell_sel};
  assign hi_idx   = lo_idx + TabIdxW'(1);
  assign hi_val   = NegLogTab[hi_idx];

  // stage 1: end point and step across the cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= NegLogTab[lo_idx];
    diff_q <= DiffW'(hi_val - NegLogTab[lo_idx]);
    frac_q <= rand_word_i[FracLsb +: FracW];
  end

  // stage 2: interpolate inside the cell
  assign step  = (DiffW+FracW)'(diff_q) * (DiffW+FracW)'(frac_q);
  assign dev_d = lo_q + TabW'(step[DiffW+FracW-1:QShift]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dev_q <= dev_d;
  end

  assign valid_o = v2_q;
  assign dev_o   = dev_q;

endmodule

/* design/truncated_exponential_sampler.sv */
// ----------------------------------------------------------------------------
// Truncated exponential sampler
// Draws a duration in ms from a uniform word via a -ln(1-u) table, scaled
// by the mean, offset by the minimum and clamped to the configured bounds.
// ----------------------------------------------------------------------------
// Fixed mode, or a maximum at or below the minimum, returns the minimum.
// Throughput: one request per cycle; busy is never raised since the four
//   register stages (lookup, interpolate, mean multiply, offset and clamp)
//   all advance every cycle and the receiver cannot stall.
// Reset: clears stage valid bits and loads mode = exponential, min = 0,
//   max = 0, mean = 1.
module truncated_exponential_sampler import tes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [RandW-1:0]   rand_word_i,
  // result channel
  output logic               done_o,
  output logic [DurW-1:0]    duration_ms_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  logic              mode_q;
  logic [DurW-1:0]   min_ms_q;
  logic [DurW-1:0]   max_ms_q;
  logic [MeanW-1:0]  mean_ms_q;
  logic              cfg_we;

  logic              accept;
  logic              v2;
  logic [TabW-1:0]   dev;

  logic [MeanW-1:0]        mean_eff;
  logic [TabW+MeanW-1:0]   prod;
  logic                    v3_q;
  logic [ScaledW-1:0]      scaled_q;

  logic [DurW:0]     sum;
  logic              use_min;
  logic [DurW-1:0]   dur_d;
  logic              v4_q;
  logic [DurW-1:0]   dur_q;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_EXP;
      min_ms_q  <= '0;
      max_ms_q  <= '0;
      mean_ms_q <= MeanW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_DIST_MODE: mode_q    <= cfg_data_i[0];
        CFG_MIN_MS:    min_ms_q  <= cfg_data_i[DurW-1:0];
        CFG_MAX_MS:    max_ms_q  <= cfg_data_i[DurW-1:0];
        CFG_MEAN_MS:   mean_ms_q <= cfg_data_i[MeanW-1:0];
        default: ;
      endcase
    end
  end

  // accept a request every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stages 1-2: table lookup and interpolation
  tes_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .rand_word_i (rand_word_i),
    .valid_o     (v2),
    .dev_o       (dev)
  );

  // stage 3: scale by the mean, keeping it at least one
  assign mean_eff = (mean_ms_q == '0) ? MeanW'(1) : mean_ms_q;
  assign prod     = (TabW+MeanW)'(dev) * (TabW+MeanW)'(mean_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    scaled_q <= prod[TabW+MeanW-1:QShift];
  end

  // stage 4: offset by the minimum and clamp
  assign sum     = {1'b0, min_ms_q} + (DurW+1)'(scaled_q);
  assign use_min = (mode_q == MODE_FIXED) || (max_ms_q <= min_ms_q);

  always_comb begin
    if (use_min) begin
      dur_d = min_ms_q;
    end else if (sum > {1'b0, max_ms_q}) begin
      dur_d = max_ms_q;
    end else begin
      dur_d = sum[DurW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q  <= 1'b0;
      dur_q <= '0;
    end else begin
      v4_q <= v3_q;
      if (v3_q) begin
        dur_q <= dur_d;
      end
    end
  end

  assign done_o        = v4_q;
  assign duration_ms_o = dur_q;

  // every accepted request later produces a done_o strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted request did not produce a result after four cycles");

  // no result without a matching earlier request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result strobe without a matching request");

  // result register only changes when a result is presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(duration_ms_o))
    else $error("duration changed without a result strobe");

  // a write to the minimum register lands in it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && (cfg_index_i == CFG_MIN_MS)) |=> (min_ms_q == $past(cfg_data_i[DurW-1:0])))
    else $error("minimum register write lost");

endmodule

/* dv/truncated_exponential_sampler_tb.sv */
// ----------------------------------------------------------------------------
// Truncated exponential sampler testbench
// Sends uniform words through the request channel and predicts each duration
// from a local copy of the -ln(1-u) table, the mean scale and the bounds.
// Directed tests cover table ends, clamping, mode and range corner cases and
// register masking; random phases then sweep settings and words. Durations
// are checked in order against a queue of predicted values.
// ----------------------------------------------------------------------------
module truncated_exponential_sampler_tb import tes_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;   // pipeline is four stages deep
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseRequests = 135;
  localparam longint unsigned DurMax = (64'd1 << DurW) - 1;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = {CfgIdxW{1'b1}};

  // -ln(1-u) at u = k/32 in Q16.16
  localparam logic [31:0] NEG_LOG_Q16 [TabN] = '{
    32'd0,      32'd2064,   32'd4184,   32'd6364,   32'd8608,   32'd10921,
    32'd13307,  32'd15772,  32'd18322,  32'd20964,  32'd23706,  32'd26556,
    32'd29525,  32'd32624,  32'd35867,  32'd39270,  32'd42851,  32'd46632,
    32'd50639,  32'd54903,  32'd59461,  32'd64358,  32'd69649,  32'd75403,
    32'd81706,  32'd88670,  32'd96444,  32'd105226, 32'd115295, 32'd127085,
    32'd141335, 32'd159487, 32'd184320
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [RandW-1:0]   rand_word_i = '0;
  logic               done_o;
  logic [DurW-1:0]    duration_ms_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;

  // local copy of the register file
  logic               cur_mode = MODE_EXP;
  logic [DurW-1:0]    cur_min = '0;
  logic [DurW-1:0]    cur_max = '0;
  logic [MeanW-1:0]   cur_mean = MeanW'(1);

  logic [DurW-1:0]    expected_durations [$];
  logic [DurW-1:0]    want_ms;
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  bit                 steady_sender = 1'b0;

  truncated_exponential_sampler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .rand_word_i   (rand_word_i),
    .done_o        (done_o),
    .duration_ms_o (duration_ms_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Generate the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hold reset at the start of the run, then release it once
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Compute the duration expected for one word under the current settings
  function automatic logic [DurW-1:0] expected_duration(input logic [RandW-1:0] word);
    int unsigned     cell_idx;
    longint unsigned frac, lo, hi, deviate, scale, total;
    if (cur_mode == MODE_FIXED || cur_max <= cur_min) return cur_min;
    cell_idx = 32'(word[31:27]);
    frac     = 64'(word[26:11]);
    lo       = 64'(NEG_LOG_Q16[cell_idx]);
    hi       = 64'(NEG_LOG_Q16[cell_idx + 1]);
    deviate  = lo + (((hi - lo) * frac) >> 16);
    scale    = (cur_mean == '0) ? 64'd1 : 64'(cur_mean);
    total    = 64'(cur_min) + ((deviate * scale) >> 16);
    if (total > 64'(cur_max)) total = 64'(cur_max);
    if (total < 64'(cur_min)) total = 64'(cur_min);
    return total[DurW-1:0];
  endfunction

  // Track register writes, predict accepted requests, check durations
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DIST_MODE: cur_mode = cfg_data_i[0];
          CFG_MIN_MS:    cur_min  = cfg_data_i[DurW-1:0];
          CFG_MAX_MS:    cur_max  = cfg_data_i[DurW-1:0];
          CFG_MEAN_MS:   cur_mean = cfg_data_i[MeanW-1:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_durations.push_back(expected_duration(rand_word_i));
      if (done_o) begin
        if (expected_durations.size() == 0) begin
          $display("%0t: duration with no request pending, expected none, actual %0d",
                   $time, duration_ms_o);
          mismatch_count++;
        end else begin
          want_ms = expected_durations.pop_front();
          if (duration_ms_o !== want_ms) begin
            $display("%0t: duration_ms expected %0d, actual %0d",
                     $time, want_ms, duration_ms_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one request, idling at random before it
  task automatic send_word(input logic [RandW-1:0] word);
    int unsigned gap;
    if (!steady_sender && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 2);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    rand_word_i <= word;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every predicted duration has come back
  task automatic drain_requests();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_durations.size() != 0) @(posedge clk_i);
  endtask

  // Put one register write on the channel, leaving valid high
  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all four registers while idle
  task automatic set_regs(input logic [31:0] mode_d, input logic [31:0] min_d,
                          input logic [31:0] max_d, input logic [31:0] mean_d);
    drain_requests();
    cfg_put(CFG_DIST_MODE, mode_d);
    cfg_put(CFG_MIN_MS, min_d);
    cfg_put(CFG_MAX_MS, max_d);
    cfg_put(CFG_MEAN_MS, mean_d);
    cfg_valid_i <= 1'b0;
  endtask

  // Pick a word, leaning on the top cell and on fraction extremes now and then
  function automatic logic [RandW-1:0] random_word();
    logic [RandW-1:0] word;
    word = $urandom;
    case ($urandom_range(0, 15))
      0, 1: word[31:27] = '1;
      2:    word[26:11] = '1;
      3:    word[26:11] = '0;
      default: ;
    endcase
    return word;
  endfunction

  task automatic test_reset_values();
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
  endtask

  task automatic test_table_extremes();
    set_regs(MODE_EXP, 32'd0, 32'h7FFF_FFFF, 32'h00FF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h07FF_F800);
    send_word(32'h0800_0000);
    send_word(32'hF800_0000);
    send_word(32'h8000_0000);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
  endtask

  task automatic test_clamp_and_offset();
    set_regs(MODE_EXP, 32'd1000, 32'd1500, 32'd4096);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h4000_0000);
    // sum runs past the 31-bit range before the clamp
    set_regs(MODE_EXP, 32'h7FFF_FF00, 32'h7FFF_FFFF, 32'h00FF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_07FF);
  endtask

  task automatic test_zero_mean();
    set_regs(MODE_EXP, 32'd7, 32'd100000, 32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
  endtask

  task automatic test_empty_and_inverted_range();
    set_regs(MODE_EXP, 32'd5000, 32'd5000, 32'd300);
    send_word(32'hFFFF_FFFF);
    set_regs(MODE_EXP, 32'd5000, 32'd4999, 32'd300);
    send_word(32'hFFFF_FFFF);
  endtask

  task automatic test_fixed_mode();
    // only bit 0 of the mode write counts
    set_regs(32'hFFFF_FFFE, 32'd12345, 32'h7FFF_FFFF, 32'd1000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h1234_5678);
  endtask

  task automatic test_masked_writes();
    set_regs(32'h0000_0003, 32'h8000_0010, 32'hFFFF_FFFF, 32'hFF00_0100);
    send_word(32'hFFFF_FFFF);
    send_word(32'hC3C3_C3C3);
  endtask

  task automatic test_unlisted_index();
    drain_requests();
    for (int idx = CFG_MEAN_MS + 1; idx <= CfgIdxTop; idx++)
      cfg_put(idx[CfgIdxW-1:0], $urandom);
    cfg_valid_i <= 1'b0;
    send_word(32'hFFFF_FFFF);
    send_word(32'h3C3C_3C3C);
  endtask

  // Sweep random settings, each phase followed by a burst of random words
  task automatic test_random_settings();
    logic [31:0]     mode_d, min_d, max_d, mean_d;
    longint unsigned lo_bound, hi_bound;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      mode_d    = $urandom;
      mode_d[0] = ($urandom_range(0, 9) == 0) ? MODE_FIXED : MODE_EXP;
      case ($urandom_range(0, 3))
        0:       lo_bound = 0;
        1:       lo_bound = 64'($urandom_range(0, 5000));
        2:       lo_bound = 64'($urandom_range(0, 32'h7FFF_FFFF));
        default: lo_bound = DurMax - 64'($urandom_range(0, 4096));
      endcase
      case ($urandom_range(0, 4))
        0, 1:    hi_bound = lo_bound + 64'($urandom_range(1, 200000));
        2:       hi_bound = DurMax;
        3:       hi_bound = 64'($urandom_range(0, 32'h7FFF_FFFF));
        default: hi_bound = lo_bound;
      endcase
      if (hi_bound > DurMax) hi_bound = DurMax;
      case ($urandom_range(0, 4))
        0:       mean_d = 0;
        1:       mean_d = 1;
        2:       mean_d = $urandom_range(1, 4096);
        3:       mean_d = $urandom_range(0, 32'h00FF_FFFF);
        default: mean_d = 32'h00FF_FFFF;
      endcase
      // hold two phases at the bound and mean extremes
      if (phase < 2) begin
        mode_d[0] = MODE_EXP;
        lo_bound  = 0;
        hi_bound  = DurMax;
        mean_d    = (phase == 0) ? 32'h00FF_FFFF : 32'd1;
      end
      // garbage above each register width must be dropped
      min_d         = {1'($urandom_range(0, 1)), lo_bound[30:0]};
      max_d         = {1'($urandom_range(0, 1)), hi_bound[30:0]};
      mean_d[31:24] = 8'($urandom_range(0, 255));
      set_regs(mode_d, min_d, max_d, mean_d);
      steady_sender = (phase == RandomPhases / 2);
      repeat (PhaseRequests) send_word(random_word());
      steady_sender = 1'b0;
    end
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    test_reset_values();
    test_table_extremes();
    test_clamp_and_offset();
    test_zero_mean();
    test_empty_and_inverted_range();
    test_fixed_mode();
    test_masked_writes();
    test_unlisted_index();
    test_random_settings();
    drain_requests();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_durations.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tes_pkg.sv
design/tes_interp.sv
design/truncated_exponential_sampler.sv
dv/truncated_exponential_sampler_tb.sv
